// ===== rtl/core/sbal_pkg.sv =====
// shared types, constants and cost/leftover functions of the greedy subband bit allocator
package sbal_pkg;

    localparam int NUM_BANDS = 4;
    localparam int LEVEL_W   = 32;
    localparam int BUDGET_W  = 10;
    localparam int STEP_W    = 10;
    localparam int BAND_W    = 2;
    localparam int COST_W    = 4;

    // band codes
    localparam logic [BAND_W-1:0] BAND_V0 = 2'd0;
    localparam logic [BAND_W-1:0] BAND_W0 = 2'd1;
    localparam logic [BAND_W-1:0] BAND_W1 = 2'd2;
    localparam logic [BAND_W-1:0] BAND_W2 = 2'd3;

    typedef logic [LEVEL_W-1:0]  level_t;
    typedef level_t [NUM_BANDS-1:0] level_vec_t;
    typedef logic [1:0]          inc_t;
    typedef inc_t [NUM_BANDS-1:0] inc_vec_t;

    // result of one allocation round
    typedef struct packed {
        logic [BUDGET_W-1:0] budget;
        inc_vec_t            inc;
    } round_t;

    function automatic logic [COST_W-1:0] band_cost(input logic [BAND_W-1:0] band);
        logic [COST_W-1:0] cost;
        unique case (band)
            BAND_V0: cost = 4'd2;
            BAND_W0: cost = 4'd3;
            BAND_W1: cost = 4'd5;
            BAND_W2: cost = 4'd10;
            default: cost = 4'd10;
        endcase
        return cost;
    endfunction

    // leftover spend for a budget the picked band cannot afford
    function automatic round_t spend_leftover(input logic [BUDGET_W-1:0] budget);
        round_t r;
        r.budget = '0;
        r.inc    = '0;
        unique case (budget)
            10'd9:
            begin
                r.inc[BAND_W1] = 2'd1;
                r.inc[BAND_V0] = 2'd2;
            end
            10'd8:
            begin
                r.inc[BAND_W1] = 2'd1;
                r.inc[BAND_W0] = 2'd1;
            end
            10'd7:
            begin
                r.inc[BAND_W1] = 2'd1;
                r.inc[BAND_V0] = 2'd1;
            end
            10'd6:
            begin
                r.inc[BAND_W0] = 2'd2;
            end
            10'd5:
            begin
                r.inc[BAND_V0] = 2'd1;
                r.inc[BAND_W0] = 2'd1;
            end
            10'd4:
            begin
                r.inc[BAND_V0] = 2'd2;
            end
            10'd3:
            begin
                r.inc[BAND_W0] = 2'd1;
            end
            10'd2:
            begin
                r.inc[BAND_V0] = 2'd1;
            end
            default:
            begin
                r.budget = budget - 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/sbal_pick.sv =====
// band picker: index of the highest working level, ties to the lowest index
module sbal_pick
    import sbal_pkg::*;
(
    input  level_vec_t        levels,
    output logic [BAND_W-1:0] band
);

    logic [BAND_W-1:0] lo_band;
    logic [BAND_W-1:0] hi_band;
    level_t            lo_level;
    level_t            hi_level;

    // two-level tournament, later index wins only when strictly greater
    always_comb
    begin
        lo_band  = (levels[1] > levels[0]) ? BAND_W0 : BAND_V0;
        hi_band  = (levels[3] > levels[2]) ? BAND_W2 : BAND_W1;
        lo_level = levels[lo_band];
        hi_level = levels[hi_band];
        band     = (hi_level > lo_level) ? hi_band : lo_band;
    end

endmodule

// ===== rtl/core/sbal_round.sv =====
// round unit: charges the picked band or spends the leftover budget
module sbal_round
    import sbal_pkg::*;
(
    input  logic                limit_mode,
    input  logic [BUDGET_W-1:0] budget,
    input  logic [BAND_W-1:0]   band,
    output round_t              rnd
);

    logic [BUDGET_W-1:0] cost;
    logic                afford;

    always_comb
    begin
        cost   = BUDGET_W'(band_cost(band));
        afford = (budget >= cost);
        rnd    = '0;
        if (!limit_mode)
        begin
            // free mode saturates the budget at zero
            rnd.inc[band] = 2'd1;
            rnd.budget    = (cost >= budget) ? '0 : budget - cost;
        end
        else if (afford)
        begin
            rnd.inc[band] = 2'd1;
            rnd.budget    = budget - cost;
        end
        else
        begin
            rnd = spend_leftover(budget);
        end
    end

endmodule

// ===== rtl/core/greedy_subband_bit_allocator.sv =====
// top level of the greedy subband bit allocator: sequencer, level and step registers
//
//  channel | signals                              | direction | transfer when
//  --------+--------------------------------------+-----------+---------------------------
//  in      | in_valid, in_stall, budget, level_*  | to block  | in_valid && !in_stall
//  out     | out_valid, out_stall, bits_*         | from block| out_valid && !out_stall
//  cfg     | cfg_valid, cfg_ready, cfg_data       | to block  | cfg_valid && cfg_ready
//
// one allocation round per cycle through the shared pick and round units; a frame takes
// an accept, at most budget/2 rounded up rounds and a finish that waits on a stalled result
// in_stall is high from the accept until the result is loaded into the output register
// a waiting result in the output register does not block a new input transfer
// reset clears the sequencer, the output valid and limit_mode; no clearing pass
module greedy_subband_bit_allocator
    import sbal_pkg::*;
#(
    parameter int MAX_BUDGET = 1023
)
(
    input  logic                clk,
    input  logic                rst_n,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BUDGET_W-1:0] budget,
    input  logic [LEVEL_W-1:0]  level_v0,
    input  logic [LEVEL_W-1:0]  level_w0,
    input  logic [LEVEL_W-1:0]  level_w1,
    input  logic [LEVEL_W-1:0]  level_w2,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STEP_W-1:0]   bits_v0,
    output logic [STEP_W-1:0]   bits_w0,
    output logic [STEP_W-1:0]   bits_w1,
    output logic [STEP_W-1:0]   bits_w2,
    // configuration channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic                limit_mode_reg;
    logic [BUDGET_W-1:0] budget_reg;
    logic [BUDGET_W-1:0] budget_next;
    level_vec_t          level_reg;
    level_vec_t          level_next;
    logic [NUM_BANDS-1:0][STEP_W-1:0] steps_reg;
    logic [NUM_BANDS-1:0][STEP_W-1:0] steps_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [NUM_BANDS-1:0][STEP_W-1:0] out_bits_reg;

    logic                in_xfer;
    logic                out_xfer;
    logic                out_load;
    logic                round_go;
    logic                clamp;
    logic [BUDGET_W-1:0] budget_in;
    logic [BAND_W-1:0]   band;
    round_t              rnd;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign cfg_ready = 1'b1;

    // a round runs while budget is left; an empty budget ends the frame
    assign round_go  = (state_reg == ST_RUN) && (budget_reg != '0);
    assign out_load  = (state_reg == ST_RUN) && (budget_reg == '0)
                       && (!out_valid_reg || !out_stall);

    // clamp the incoming budget to the configured maximum
    assign clamp     = (32'(budget) > 32'(MAX_BUDGET));
    assign budget_in = clamp ? BUDGET_W'(MAX_BUDGET) : budget;

    sbal_pick u_pick
    (
        .levels (level_reg),
        .band   (band)
    );

    sbal_round u_round
    (
        .limit_mode (limit_mode_reg),
        .budget     (budget_reg),
        .band       (band),
        .rnd        (rnd)
    );

    always_comb
    begin
        state_next     = state_reg;
        budget_next    = budget_reg;
        level_next     = level_reg;
        steps_next     = steps_reg;
        out_valid_next = out_valid_reg;
        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next    = ST_RUN;
                    budget_next   = budget_in;
                    level_next[0] = level_v0;
                    level_next[1] = level_w0;
                    level_next[2] = level_w1;
                    level_next[3] = level_w2;
                    steps_next    = '0;
                end
            end
            ST_RUN:
            begin
                if (round_go)
                begin
                    // picked level drops by one with wrap, steps count modulo 2^STEP_W
                    level_next[band] = level_reg[band] - 1'b1;
                    budget_next      = rnd.budget;
                    for (int k = 0; k < NUM_BANDS; k++)
                    begin
                        steps_next[k] = steps_reg[k] + STEP_W'(rnd.inc[k]);
                    end
                end
                else if (out_load)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            limit_mode_reg <= 1'b0;
            budget_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            budget_reg    <= budget_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_mode_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        level_reg <= level_next;
        steps_reg <= steps_next;
        if (out_load)
        begin
            out_bits_reg <= steps_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign bits_v0   = out_bits_reg[0];
    assign bits_w0   = out_bits_reg[1];
    assign bits_w1   = out_bits_reg[2];
    assign bits_w2   = out_bits_reg[3];

`ifndef SYNTHESIS
    // an input transfer starts a run
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_RUN))
        else $error("run did not start after input transfer");

    // every round spends at least one bit
    assert property (@(posedge clk) disable iff (!rst_n)
        round_go |=> (budget_reg < $past(budget_reg)))
        else $error("round did not reduce the budget");

    // finishing a frame presents the result and frees the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("result not presented after finish");

    // an idle block holds no budget
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (budget_reg == '0))
        else $error("budget left while idle");
`endif

endmodule
